[rtl/sidec_pkg.sv]
// sidec_pkg: shared constants and types for the signed integer to decimal text unit
// no dependencies; used by the character interface, the dabble step and the top level
package sidec_pkg;

	// output field widths
	localparam int CHAR_W  = 6;
	localparam int LEN_W   = 4;

	// one packed bcd digit
	localparam int DIGIT_W = 4;

	// ascii codes, cut to the character field width
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

	// threshold of the shift-add-3 correction
	localparam logic [DIGIT_W-1:0] DIGIT_FIVE  = DIGIT_W'(5);
	localparam logic [DIGIT_W-1:0] DIGIT_THREE = DIGIT_W'(3);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SKIP = 4'b0100,
		ST_EMIT = 4'b1000
	} sidec_state_t;

endpackage

[rtl/sidec_value_if.sv]
// sidec_value_if: input channel carrying one signed integer per item
// depends on nothing; width set by parameter
interface sidec_value_if #(
	parameter int VALUE_WIDTH = 32
) ();
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

[rtl/sidec_char_if.sv]
// sidec_char_if: output channel carrying one ascii character per item
// depends on sidec_pkg for field widths
interface sidec_char_if import sidec_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last;
	logic [LEN_W-1:0]  length;

	modport source (output valid, output character, output last, output length, input ready);
	modport sink   (input valid, input character, input last, input length, output ready);
endinterface

[rtl/sidec_dabble.sv]
// sidec_dabble: one shift-add-3 step of binary to bcd conversion
// depends on sidec_pkg for the digit width and correction constants
module sidec_dabble import sidec_pkg::*; #(
	parameter int DIGITS = 10,
	parameter int BIN_W  = 32
) (
	input  logic [DIGITS*DIGIT_W-1:0] bcd,
	input  logic [BIN_W-1:0]          bin,
	output logic [DIGITS*DIGIT_W-1:0] bcd_nxt,
	output logic [BIN_W-1:0]          bin_nxt
);

	logic [DIGITS*DIGIT_W-1:0] adj;

	// add 3 to every digit of 5 or more, then shift one bit in from the binary word
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_FIVE) begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_THREE;
			end else begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	assign bcd_nxt = {adj[DIGITS*DIGIT_W-2:0], bin[BIN_W-1]};
	assign bin_nxt = {bin[BIN_W-2:0], 1'b0};

endmodule

[rtl/signed_int_to_decimal_ascii_unit.sv]
// signed_int_to_decimal_ascii_unit: top level of the integer to decimal text converter
// depends on sidec_pkg, sidec_value_if, sidec_char_if and sidec_dabble

// Takes one signed two's-complement integer per item on number and sends its
// decimal text on text, one character per item, most significant first: a
// leading '-' for negative values, then the digits with no leading zeros
// (zero gives a single '0'). The most negative value converts exactly. The
// final character has last set and carries the total character count in
// length (count modulo 16); length is 0 on every other character. The idle
// state takes the item, the magnitude passes through a shift-add-3 (double
// dabble) step one bit per cycle, leading zero digits are then dropped one
// per cycle, and characters leave one per cycle while text is ready.
// Dropped and sent digits always add up to NDIG, where NDIG is the digit
// count of 2^(VALUE_WIDTH-1). number.ready is high only while idle.
module signed_int_to_decimal_ascii_unit import sidec_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	sidec_value_if.sink   number,
	sidec_char_if.source  text
);

	// digits of the largest magnitude, 2^(VALUE_WIDTH-1): floor((w-1)*log10(2)) + 1
	localparam int NDIG  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int BCD_W = NDIG * DIGIT_W;
	localparam int CNT_W = $clog2(NDIG + 1);
	localparam int TOT_W = CNT_W + 1;
	localparam int BIT_W = $clog2(VALUE_WIDTH);

	sidec_state_t           state_q;
	logic [VALUE_WIDTH-1:0] bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BIT_W-1:0]       bit_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   neg_q;
	logic [TOT_W-1:0]       total_q;

	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag;
	logic [VALUE_WIDTH-1:0] bin_nxt;
	logic [BCD_W-1:0]       bcd_nxt;
	logic [BCD_W-1:0]       bcd_shl;
	logic [DIGIT_W-1:0]     top_digit;
	logic                   last_char;

	// magnitude formed unsigned, so the most negative value maps to 2^(w-1)
	assign raw = number.value;
	assign mag = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;

	// shared conversion step
	sidec_dabble #(
		.DIGITS (NDIG),
		.BIN_W  (VALUE_WIDTH)
	) u_dabble (
		.bcd     (bcd_q),
		.bin     (bin_q),
		.bcd_nxt (bcd_nxt),
		.bin_nxt (bin_nxt)
	);

	// digit shifter: top digit always holds the next one to send
	assign top_digit = bcd_q[BCD_W-1 -: DIGIT_W];
	assign bcd_shl   = {bcd_q[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};

	// the minus sign never ends a run, so last waits for the final digit
	assign last_char = !neg_q && (cnt_q == CNT_W'(1));

	assign number.ready   = (state_q == ST_IDLE);
	assign text.valid     = (state_q == ST_EMIT);
	assign text.character = neg_q ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(top_digit));
	assign text.last      = last_char;
	assign text.length    = last_char ? LEN_W'(total_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			neg_q   <= 1'b0;
			cnt_q   <= '0;
			bit_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (number.valid) begin
						neg_q   <= raw[VALUE_WIDTH-1];
						bit_q   <= BIT_W'(VALUE_WIDTH - 1);
						state_q <= ST_CONV;
					end
				end
				// one magnitude bit per cycle into the bcd register
				ST_CONV: begin
					bit_q <= bit_q - BIT_W'(1);
					if (bit_q == '0) begin
						cnt_q   <= CNT_W'(NDIG);
						state_q <= ST_SKIP;
					end
				end
				// drop leading zero digits, keeping at least one digit
				ST_SKIP: begin
					if (top_digit == '0 && cnt_q != CNT_W'(1)) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				// one character per accepted item, sign first
				ST_EMIT: begin
					if (text.ready) begin
						if (neg_q) begin
							neg_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q - CNT_W'(1);
							if (cnt_q == CNT_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (number.valid) begin
					bin_q <= mag;
					bcd_q <= '0;
				end
			end
			ST_CONV: begin
				bin_q <= bin_nxt;
				bcd_q <= bcd_nxt;
			end
			ST_SKIP: begin
				if (top_digit == '0 && cnt_q != CNT_W'(1)) begin
					bcd_q <= bcd_shl;
				end else begin
					total_q <= {1'b0, cnt_q} + TOT_W'(neg_q);
				end
			end
			ST_EMIT: begin
				if (text.ready && !neg_q) begin
					bcd_q <= bcd_shl;
				end
			end
			default: begin
				bcd_q <= bcd_q;
			end
		endcase
	end

endmodule
